>>> src/sleep_deadline_queue_top_defines.svh
// Assertion macros used by the sleeper queue top level.
`ifndef SLEEP_DEADLINE_QUEUE_TOP_DEFINES_SVH
`define SLEEP_DEADLINE_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SDQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDQ_ASSERT_IMPL(label, ante, cons, msg)
`define SDQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> src/sdq_pkg.sv
// Shared constants and types of the sleeper queue.
package sdq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS);
    localparam int TICK_W      = 63;
    localparam int WAKE_W      = 64;
    localparam int THREAD_W    = 8;
    localparam int DUR_W       = 32;
    localparam int KIND_W      = 3;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_SLEEP = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WOKEN    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd4;

    typedef struct packed {
        logic [WAKE_W-1:0]   wake;
        logic [THREAD_W-1:0] thread;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic   ins;
        logic   pop;
        entry_t new_entry;
    } cmd_t;

endpackage

>>> src/sdq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
module sdq_cell (
    input  logic           aclk,
    input  sdq_pkg::cmd_t  cmd,
    input  logic           valid_in,
    input  logic           left_keep,
    input  sdq_pkg::entry_t left_entry,
    input  sdq_pkg::entry_t right_entry,
    output sdq_pkg::entry_t entry,
    output logic           keep
);
    import sdq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // An occupied slot whose deadline is not later than the new one stays put.
    assign keep  = valid_in && (entry_reg.wake <= cmd.new_entry.wake);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (keep) begin
                entry_next = entry_reg;
            end else if (left_keep) begin
                entry_next = cmd.new_entry;
            end else begin
                entry_next = left_entry;
            end
        end else if (cmd.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> src/sdq_chain.sv
// Row of queue cells; the head sits in cell zero.
module sdq_chain (
    input  logic                     aclk,
    input  sdq_pkg::cmd_t            cmd,
    input  logic [sdq_pkg::CNT_W-1:0] count,
    output sdq_pkg::entry_t          head0,
    output sdq_pkg::entry_t          head1
);
    import sdq_pkg::*;

    entry_t entries [QUEUE_DEPTH];
    logic   keeps   [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic   valid_w;
        logic   left_keep_w;
        entry_t left_w;
        entry_t right_w;

        assign valid_w = CNT_W'(i) < count;

        if (i == 0) begin : g_first
            // The slot left of the head acts as an entry that always stays.
            assign left_keep_w = 1'b1;
            assign left_w      = cmd.new_entry;
        end else begin : g_inner
            assign left_keep_w = keeps[i-1];
            assign left_w      = entries[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_body
            assign right_w = entries[i+1];
        end

        sdq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .valid_in    (valid_w),
            .left_keep   (left_keep_w),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entries[i]),
            .keep        (keeps[i])
        );
    end

    assign head0 = entries[0];
    assign head1 = entries[1];

endmodule

>>> src/sleep_deadline_queue_top.sv
// Top level of the sleeper queue: handshakes, tick counter and release sequencer.
//
//  channel   dir  tdata (low bit first)                 tuser    tlast
//  s_        in   thread_id[7:0], sleep_ticks[39:8]     opcode   -
//  m_        out  woken_thread[7:0], tick_now[70:8]     kind     last result
//
// A sleep request's sorted insert into the cell row and its result both happen at the
// transfer. A tick advances the counter; the sequencer then releases due sleepers by
// the single pop of the head cell per cycle while the output is free, or gives one
// result when none is due.
// Reset clears the tick counter and the fill count; cell contents need no reset.
// A stalled result holds in the output register and the sequencer waits on it.
`include "sleep_deadline_queue_top_defines.svh"

module sleep_deadline_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // thread_id[7:0], sleep_ticks[39:8]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // woken_thread[7:0], tick_now[70:8], zero[71]
    output logic [2:0]  m_tuser,   // kind[2:0]
    output logic        m_tlast
);
    import sdq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RELEASE
    } state_t;

    state_t              state_reg,  state_next;
    logic [TICK_W-1:0]   tick_reg,   tick_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [RES_W-1:0]    rel_reg,    rel_next;
    logic                mvalid_reg, mvalid_next;
    logic [KIND_W-1:0]   mkind_reg,  mkind_next;
    logic [THREAD_W-1:0] mthr_reg,   mthr_next;
    logic [TICK_W-1:0]   mtick_reg,  mtick_next;
    logic                mlast_reg,  mlast_next;

    cmd_t                cmd;
    entry_t              head0;
    entry_t              head1;
    logic                out_free;
    logic                s_fire;
    logic                op;
    logic [THREAD_W-1:0] in_thread;
    logic [DUR_W-1:0]    in_ticks;
    logic                ignored;
    logic                full;
    logic [WAKE_W-1:0]   tick_wide;
    logic                head0_due;
    logic                head1_due;
    logic                rel_last;

    assign out_free  = !mvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire    = s_tvalid && s_tready;
    assign op        = s_tuser[0];
    assign in_thread = s_tdata[7:0];
    assign in_ticks  = s_tdata[39:8];

    assign ignored   = in_ticks[DUR_W-1] || (in_ticks == '0);
    assign full      = count_reg >= CNT_W'(QUEUE_DEPTH);
    assign tick_wide = {{(WAKE_W-TICK_W){1'b0}}, tick_reg};
    assign head0_due = (count_reg != '0) && (head0.wake <= tick_wide);
    assign head1_due = (count_reg > CNT_W'(1)) && (head1.wake <= tick_wide);
    assign rel_last  = !(head1_due && (rel_reg != RES_W'(MAX_RESULTS - 1)));

    sdq_chain u_chain (
        .aclk  (aclk),
        .cmd   (cmd),
        .count (count_reg),
        .head0 (head0),
        .head1 (head1)
    );

    always_comb begin
        state_next  = state_reg;
        tick_next   = tick_reg;
        count_next  = count_reg;
        rel_next    = rel_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mkind_next  = mkind_reg;
        mthr_next   = mthr_reg;
        mtick_next  = mtick_reg;
        mlast_next  = mlast_reg;

        cmd.ins              = 1'b0;
        cmd.pop              = 1'b0;
        cmd.new_entry.wake   = tick_wide + {{(WAKE_W-DUR_W){1'b0}}, in_ticks};
        cmd.new_entry.thread = in_thread;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (op == OP_SLEEP) begin
                        mvalid_next = 1'b1;
                        mthr_next   = '0;
                        mtick_next  = tick_reg;
                        mlast_next  = 1'b1;
                        if (ignored) begin
                            mkind_next = KIND_IGNORED;
                        end else if (full) begin
                            mkind_next = KIND_FULL;
                        end else begin
                            mkind_next = KIND_ACCEPTED;
                            cmd.ins    = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else begin
                        // The counter saturates at the top of tick_now.
                        if (tick_reg != {TICK_W{1'b1}}) begin
                            tick_next = tick_reg + TICK_W'(1);
                        end
                        rel_next   = '0;
                        state_next = ST_RELEASE;
                    end
                end
            end
            ST_RELEASE: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mtick_next  = tick_reg;
                    if (head0_due) begin
                        mkind_next = KIND_WOKEN;
                        mthr_next  = head0.thread;
                        mlast_next = rel_last;
                        cmd.pop    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                        rel_next   = rel_reg + RES_W'(1);
                        if (rel_last) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        mkind_next = KIND_NONE;
                        mthr_next  = '0;
                        mlast_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tick_reg   <= '0;
            count_reg  <= '0;
            rel_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            count_reg  <= count_next;
            rel_reg    <= rel_next;
            mvalid_reg <= mvalid_next;
        end
        mkind_reg <= mkind_next;
        mthr_reg  <= mthr_next;
        mtick_reg <= mtick_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = mkind_reg;
    assign m_tdata  = {1'b0, mtick_reg, mthr_reg};
    assign m_tlast  = mlast_reg;

    `SDQ_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "fill count overflow")
    `SDQ_ASSERT_IMPL(a_pop_nonempty, cmd.pop, count_reg != '0, "release from empty queue")
    `SDQ_ASSERT_NEXT(a_tick_release, s_fire && (op == OP_TICK), state_reg == ST_RELEASE, "tick not sequenced")
    `SDQ_ASSERT_NEXT(a_tick_mono, 1'b1, tick_reg >= $past(tick_reg), "tick counter went back")

endmodule

>>> test/tb.sv
// Self-checking testbench for the sleeper queue: sorted wake-ups, refusals and tick releases.
`timescale 1ns / 1ps

module tb;
    import sdq_pkg::*;

    localparam int ITEM_COUNT   = 260;
    localparam int QUIET_TAIL   = 40;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [WAKE_W-1:0] TICK_CEIL = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [THREAD_W-1:0] thread;
        logic [TICK_W-1:0]   tick_now;
        logic                last;
    } wake_result_t;

    // Mirrors the tick counter and the sorted sleeper list and queues up the results
    // that each accepted transfer must produce.
    class sleeper_scoreboard;
        logic [WAKE_W-1:0] tick_count;
        entry_t            sleepers[$];
        wake_result_t      expected[$];
        int                errors;

        function new();
            tick_count = '0;
            errors     = 0;
        endfunction

        function void push_result(logic [KIND_W-1:0] kind, logic [THREAD_W-1:0] thr,
                                  logic last);
            wake_result_t r;
            r.kind     = kind;
            r.thread   = thr;
            r.tick_now = tick_count[TICK_W-1:0];
            r.last     = last;
            expected.push_back(r);
        endfunction

        function void note_input(logic op, logic [THREAD_W-1:0] thr,
                                 logic [DUR_W-1:0] dur);
            entry_t e;
            int     pos;
            int     released;
            if (op == OP_SLEEP) begin
                if (dur[DUR_W-1] || dur == '0) begin
                    push_result(KIND_IGNORED, '0, 1'b1);
                end else if (sleepers.size() >= QUEUE_DEPTH) begin
                    push_result(KIND_FULL, '0, 1'b1);
                end else begin
                    e.wake   = tick_count + {{(WAKE_W-DUR_W){1'b0}}, dur};
                    e.thread = thr;
                    // Equal deadlines keep request order: insert after every wake <= new.
                    pos = 0;
                    while (pos < sleepers.size() && sleepers[pos].wake <= e.wake)
                        pos++;
                    sleepers.insert(pos, e);
                    push_result(KIND_ACCEPTED, '0, 1'b1);
                end
            end else begin
                if (tick_count < TICK_CEIL)
                    tick_count = tick_count + 1;
                released = 0;
                while (released < MAX_RESULTS && sleepers.size() > 0 &&
                       sleepers[0].wake <= tick_count) begin
                    push_result(KIND_WOKEN, sleepers[0].thread, 1'b0);
                    void'(sleepers.pop_front());
                    released++;
                end
                if (released == 0)
                    push_result(KIND_NONE, '0, 1'b1);
                else
                    expected[expected.size()-1].last = 1'b1;
            end
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [THREAD_W-1:0] thr,
                                   logic [TICK_W-1:0] tick_now, logic last);
            wake_result_t r;
            if (expected.size() == 0) begin
                $error("unexpected result transfer: kind %0d, thread %0d, tick %0d",
                       kind, thr, tick_now);
                errors++;
                return;
            end
            r = expected.pop_front();
            if (kind !== r.kind) begin
                $error("kind: expected %0d, actual %0d", r.kind, kind);
                errors++;
            end
            if (thr !== r.thread) begin
                $error("woken_thread: expected %0d, actual %0d", r.thread, thr);
                errors++;
            end
            if (tick_now !== r.tick_now) begin
                $error("tick_now: expected %0d, actual %0d", r.tick_now, tick_now);
                errors++;
            end
            if (last !== r.last) begin
                $error("last: expected %0d, actual %0d", r.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // thread_id[7:0], sleep_ticks[39:8]
    logic [0:0]  s_tuser;   // opcode[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // woken_thread[7:0], tick_now[70:8], zero[71]
    logic [2:0]  m_tuser;   // kind[2:0]
    logic        m_tlast;

    sleeper_scoreboard sb;
    bit quiet;
    bit hold_req;
    int cycles = 0;

    sleep_deadline_queue_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sleep_deadline_queue_top: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [THREAD_W-1:0] thr,
                             input logic [DUR_W-1:0] dur);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {dur, thr};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, thr, dur);
    endtask

    // The sender goes silent until every queued result has been transferred.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Result side: checks each transfer and throttles m_tready.
    initial begin
        int idle_left;
        int hold_left;
        bit hold_done;
        idle_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[7:0], m_tdata[70:8], m_tlast);
            if (hold_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(1, 4) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int               i;
        int               pick;
        logic [7:0]       thr;
        logic [DUR_W-1:0] noise;

        sb       = new();
        quiet    = 1'b0;
        hold_req = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_TICK;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty tick with junk operands, the non-positive durations,
        // the largest duration, a one-tick sleep, then a burst of equal deadlines
        // that fills the queue, a refused request, and ticks that wake them all at once.
        send_item(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
        send_item(OP_SLEEP, 8'h00, 32'h0000_0000);
        send_item(OP_SLEEP, 8'hFF, 32'h8000_0000);
        send_item(OP_SLEEP, 8'h01, 32'hFFFF_FFFF);
        send_item(OP_SLEEP, 8'h02, 32'h7FFF_FFFF);
        send_item(OP_SLEEP, 8'h03, 32'd1);
        send_item(OP_TICK, 8'h00, 32'd0);
        for (i = 0; i < QUEUE_DEPTH - 1; i++)
            send_item(OP_SLEEP, 8'(8'h10 + i * 17), 32'd3);
        send_item(OP_SLEEP, 8'hAA, 32'd5);
        for (i = 0; i < 3; i++)
            send_item(OP_TICK, 8'(i), 32'(i));
        wait_for_drain();

        for (i = 0; i < ITEM_COUNT; i++) begin
            quiet = (i >= ITEM_COUNT - QUIET_TAIL);
            if (i == 90)
                hold_req = 1'b1;
            if (i == 180)
                wait_for_drain();
            pick  = $urandom_range(0, 99);
            thr   = 8'($urandom_range(0, 255));
            noise = $urandom;
            if (pick < 42)
                send_item(OP_TICK, thr, noise);
            else if (pick < 82)
                send_item(OP_SLEEP, thr, 32'($urandom_range(1, 24)));
            else if (pick < 92)
                send_item(OP_SLEEP, thr, {1'b1, noise[30:0]});
            else if (pick < 95)
                send_item(OP_SLEEP, thr, 32'd0);
            else
                send_item(OP_SLEEP, thr, 32'($urandom_range(25, 400)));
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("sleep_deadline_queue_top: match");
        else
            $display("sleep_deadline_queue_top: mismatch");
        $finish;
    end

endmodule

>>> sleep_deadline_queue_top.f
+incdir+src
src/sdq_pkg.sv
src/sdq_cell.sv
src/sdq_chain.sv
src/sleep_deadline_queue_top.sv
test/tb.sv
